FILE: src/rsmr_pkg.sv
`timescale 1ns / 1ps
package rsmr_pkg;

    localparam int IN_WIDTH  = 16;
    localparam int NUM_WIDTH = 50;
    localparam int DEN_WIDTH = 49;
    localparam int PROD_W    = 2 * IN_WIDTH + 1;
    localparam int MAG_W     = 3 * IN_WIDTH + 1;
    localparam int CNT_W     = $clog2(MAG_W + 1);
    localparam int QDEPTH    = 2;

    typedef logic signed [IN_WIDTH-1:0] in_t;
    typedef logic [MAG_W-1:0]           mag_t;

    typedef struct packed {
        logic dz;
        logic zero;
        logic neg;
        mag_t nmag;
        mag_t dmag;
    } job_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DIFF,
        PH_SCALE,
        PH_EMIT
    } front_phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_DONE
    } back_state_t;

endpackage

FILE: src/rsmr_front.sv
`timescale 1ns / 1ps
module rsmr_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  rsmr_pkg::in_t   a,
    input  rsmr_pkg::in_t   b,
    input  rsmr_pkg::in_t   c,
    input  rsmr_pkg::in_t   d,
    input  rsmr_pkg::in_t   e,
    input  rsmr_pkg::in_t   f,
    output logic            job_valid,
    input  logic            job_stall,
    output rsmr_pkg::job_t  job
);
    localparam int PW = rsmr_pkg::PROD_W;
    localparam int MW = rsmr_pkg::MAG_W;

    // idle: cross products, diff: difference, scale: times e and f, emit: sign and magnitude
    rsmr_pkg::front_phase_t phase_reg, phase_next;
    logic signed [PW-1:0] ad_reg, cb_reg, bd_reg;
    logic signed [PW-1:0] diff_reg;
    logic signed [MW-1:0] num_reg, den_reg;
    rsmr_pkg::in_t e_reg, f_reg;
    logic dz_reg;
    logic out_valid_reg, out_valid_next;
    rsmr_pkg::job_t job_reg;
    logic signed [MW-1:0] num_w, den_w;

    assign in_stall  = (phase_reg != rsmr_pkg::PH_IDLE) || out_valid_reg;
    assign job_valid = out_valid_reg;
    assign job       = job_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !job_stall)
            out_valid_next = 1'b0;
        unique case (phase_reg)
            rsmr_pkg::PH_IDLE:
                if (in_valid && !in_stall) phase_next = rsmr_pkg::PH_DIFF;
            rsmr_pkg::PH_DIFF:  phase_next = rsmr_pkg::PH_SCALE;
            rsmr_pkg::PH_SCALE: phase_next = rsmr_pkg::PH_EMIT;
            rsmr_pkg::PH_EMIT:
            begin
                phase_next     = rsmr_pkg::PH_IDLE;
                out_valid_next = 1'b1;
            end
            default: phase_next = rsmr_pkg::PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= rsmr_pkg::PH_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign num_w = MW'(diff_reg) * MW'(e_reg);
    assign den_w = MW'(bd_reg) * MW'(f_reg);

    always_ff @(posedge clk)
    begin
        case (phase_reg)
            rsmr_pkg::PH_IDLE:
            begin
                ad_reg <= PW'(a) * PW'(d);
                cb_reg <= PW'(c) * PW'(b);
                bd_reg <= PW'(b) * PW'(d);
                e_reg  <= e;
                f_reg  <= f;
                dz_reg <= (b == '0) || (d == '0) || (f == '0);
            end
            rsmr_pkg::PH_DIFF: diff_reg <= ad_reg - cb_reg;
            rsmr_pkg::PH_SCALE:
            begin
                num_reg <= num_w;
                den_reg <= den_w;
            end
            rsmr_pkg::PH_EMIT:
            begin
                job_reg.dz   <= dz_reg;
                job_reg.zero <= (num_reg == '0);
                job_reg.neg  <= num_reg[MW-1] ^ den_reg[MW-1];
                job_reg.nmag <= num_reg[MW-1] ? MW'(-num_reg) : MW'(num_reg);
                job_reg.dmag <= den_reg[MW-1] ? MW'(-den_reg) : MW'(den_reg);
            end
            default: ;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == rsmr_pkg::PH_EMIT) |=> job_valid)
    else $error("front result missing");
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (phase_reg == rsmr_pkg::PH_DIFF))
    else $error("front phase not started");
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != rsmr_pkg::PH_IDLE) |-> in_stall)
    else $error("front accepted while busy");
endmodule

FILE: src/rsmr_queue.sv
`timescale 1ns / 1ps
module rsmr_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_stall,
    input  rsmr_pkg::job_t  wr_data,
    output logic            rd_valid,
    input  logic            rd_stall,
    output rsmr_pkg::job_t  rd_data
);
    localparam int D = rsmr_pkg::QDEPTH;
    localparam int AW = $clog2(D);

    rsmr_pkg::job_t mem_reg [D];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic wr, rd;

    assign wr_stall = (cnt_reg == (AW+1)'(D));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && !wr_stall;
    assign rd = rd_valid && !rd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= (wp_reg == AW'(D-1)) ? '0 : wp_reg + 1'b1;
            if (rd) rp_reg <= (rp_reg == AW'(D-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= wr_data;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(D))
    else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr && !rd) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
    else $error("queue count");
    assert property (@(posedge clk) disable iff (!rst_n)
        (rd && !wr) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
    else $error("queue count down");
endmodule

FILE: src/rsmr_back.sv
`timescale 1ns / 1ps
module rsmr_back
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 job_valid,
    output logic                                 job_stall,
    input  rsmr_pkg::job_t                       job,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [rsmr_pkg::NUM_WIDTH-1:0] ratio_num,
    output logic [rsmr_pkg::DEN_WIDTH-1:0]        result_den,
    output logic                                 div_by_zero
);
    localparam int MW = rsmr_pkg::MAG_W;
    localparam int CW = rsmr_pkg::CNT_W;

    rsmr_pkg::back_state_t st_reg, st_next;
    rsmr_pkg::job_t j_reg;
    rsmr_pkg::mag_t x_reg, y_reg, g_reg, q_reg, r_reg, nq_reg;
    logic [CW-1:0] bit_reg;
    logic dstart_reg;
    logic [MW:0] trial;
    rsmr_pkg::mag_t rem_sh;
    rsmr_pkg::mag_t dividend;
    rsmr_pkg::mag_t divisor;
    logic div_last;
    logic signed [rsmr_pkg::NUM_WIDTH-1:0] num_reg;
    logic [rsmr_pkg::DEN_WIDTH-1:0] den_reg;
    logic dz_reg;

    assign job_stall   = (st_reg != rsmr_pkg::ST_IDLE);
    assign out_valid   = (st_reg == rsmr_pkg::ST_DONE);
    assign ratio_num   = num_reg;
    assign result_den  = den_reg;
    assign div_by_zero = dz_reg;

    // shared restoring divider, one quotient bit per cycle
    always_comb
    begin
        dividend = x_reg;
        divisor  = y_reg;
        case (st_reg)
            rsmr_pkg::ST_DIVN:
            begin
                dividend = j_reg.nmag;
                divisor  = g_reg;
            end
            rsmr_pkg::ST_DIVD:
            begin
                dividend = j_reg.dmag;
                divisor  = g_reg;
            end
            default: ;
        endcase
        rem_sh   = {r_reg[MW-2:0], dividend[bit_reg]};
        trial    = {1'b0, rem_sh} - {1'b0, divisor};
        div_last = (bit_reg == '0);
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            rsmr_pkg::ST_IDLE:
                if (job_valid)
                    st_next = (job.dz || job.zero) ? rsmr_pkg::ST_DONE : rsmr_pkg::ST_GCD;
            rsmr_pkg::ST_GCD:
                if (!dstart_reg && y_reg == '0) st_next = rsmr_pkg::ST_DIVN;
            rsmr_pkg::ST_DIVN:
                if (!dstart_reg && div_last) st_next = rsmr_pkg::ST_DIVD;
            rsmr_pkg::ST_DIVD:
                if (!dstart_reg && div_last) st_next = rsmr_pkg::ST_DONE;
            rsmr_pkg::ST_DONE:
                if (!out_stall) st_next = rsmr_pkg::ST_IDLE;
            default: st_next = rsmr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) st_reg <= rsmr_pkg::ST_IDLE;
        else        st_reg <= st_next;
    end

    always_ff @(posedge clk)
    begin
        dstart_reg <= 1'b0;
        unique case (st_reg)
            rsmr_pkg::ST_IDLE:
            begin
                j_reg      <= job;
                x_reg      <= job.nmag;
                y_reg      <= job.dmag;
                dz_reg     <= job.dz;
                num_reg    <= '0;
                den_reg    <= rsmr_pkg::DEN_WIDTH'(1);
                dstart_reg <= 1'b1;
            end
            rsmr_pkg::ST_GCD, rsmr_pkg::ST_DIVN, rsmr_pkg::ST_DIVD:
            begin
                if (dstart_reg)
                begin
                    r_reg   <= '0;
                    q_reg   <= '0;
                    bit_reg <= CW'(MW - 1);
                    if (st_reg == rsmr_pkg::ST_GCD && y_reg == '0)
                        g_reg <= x_reg;
                end
                else if (st_reg == rsmr_pkg::ST_GCD && y_reg == '0)
                begin
                    g_reg      <= x_reg;
                    dstart_reg <= 1'b1;
                end
                else
                begin
                    r_reg   <= trial[MW] ? rem_sh : trial[MW-1:0];
                    q_reg   <= {q_reg[MW-2:0], ~trial[MW]};
                    if (!div_last)
                        bit_reg <= bit_reg - 1'b1;
                    if (div_last)
                    begin
                        dstart_reg <= 1'b1;
                        if (st_reg == rsmr_pkg::ST_GCD)
                        begin
                            x_reg <= y_reg;
                            y_reg <= trial[MW] ? rem_sh : trial[MW-1:0];
                        end
                        else if (st_reg == rsmr_pkg::ST_DIVN)
                            nq_reg <= {q_reg[MW-2:0], ~trial[MW]};
                        else
                        begin
                            num_reg <= j_reg.neg ? -rsmr_pkg::NUM_WIDTH'(nq_reg)
                                                 : rsmr_pkg::NUM_WIDTH'(nq_reg);
                            den_reg <= rsmr_pkg::DEN_WIDTH'({q_reg[MW-2:0], ~trial[MW]});
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && div_by_zero) |-> (ratio_num == '0 && result_den == 1))
    else $error("zero denominator result");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (result_den != '0))
    else $error("zero result denominator");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
    else $error("result dropped");
endmodule

FILE: src/rational_sub_mul_reduce.sv
`timescale 1ns / 1ps
// channel  direction  handshake            payload
// input    in         in_valid / in_stall  first_num .. factor_den (16b signed each)
// output   out        out_valid / out_stall ratio_num (50b s), result_den (49b), div_by_zero
//
// front: cross multiplication through the idle, diff, scale and emit phases, then a 2-entry queue to the back
// back: euclid with a bit-serial divider, then two exact divisions of the
// magnitudes by the gcd, numerator first
// reset clears the state machines and queue pointers asynchronously; no clearing pass
// zero numerator or zero denominator transactions go straight from idle to done in the back, skipping the divider
module rational_sub_mul_reduce
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  rsmr_pkg::in_t                         first_num,
    input  rsmr_pkg::in_t                         first_den,
    input  rsmr_pkg::in_t                         second_num,
    input  rsmr_pkg::in_t                         second_den,
    input  rsmr_pkg::in_t                         factor_num,
    input  rsmr_pkg::in_t                         factor_den,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [rsmr_pkg::NUM_WIDTH-1:0] ratio_num,
    output logic [rsmr_pkg::DEN_WIDTH-1:0]        result_den,
    output logic                                  div_by_zero
);
    rsmr_pkg::job_t f_job, q_job;
    logic f_valid, f_stall, q_valid, q_stall;

    rsmr_front u_front
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .a(first_num), .b(first_den), .c(second_num), .d(second_den),
        .e(factor_num), .f(factor_den),
        .job_valid(f_valid), .job_stall(f_stall), .job(f_job)
    );

    rsmr_queue u_queue
    (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_job),
        .rd_valid(q_valid), .rd_stall(q_stall), .rd_data(q_job)
    );

    rsmr_back u_back
    (
        .clk(clk), .rst_n(rst_n),
        .job_valid(q_valid), .job_stall(q_stall), .job(q_job),
        .out_valid(out_valid), .out_stall(out_stall),
        .ratio_num(ratio_num), .result_den(result_den),
        .div_by_zero(div_by_zero)
    );
endmodule

FILE: verif/rational_sub_mul_reduce_test.sv
`timescale 1ns / 1ps
module rational_sub_mul_reduce_test;
    localparam int NW = rsmr_pkg::NUM_WIDTH;
    localparam int DW = rsmr_pkg::DEN_WIDTH;
    localparam int IW = rsmr_pkg::IN_WIDTH;

    typedef struct {
        logic signed [NW-1:0] num;
        logic [DW-1:0]        den;
        logic                 dz;
    } ratio_t;

    typedef struct {
        rsmr_pkg::in_t a, b, c, d, e, f;
        logic          typed;
        ratio_t        want;
    } row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    rsmr_pkg::in_t first_num, first_den, second_num, second_den, factor_num, factor_den;
    logic out_valid;
    logic out_stall;
    logic signed [NW-1:0] ratio_num;
    logic [DW-1:0]        result_den;
    logic                 div_by_zero;

    ratio_t pending_ratios[$];
    row_t   stim_rows[$];
    int     fail_count;
    int     sent_count;
    int     got_count;
    int     dz_count;
    bit     send_done;

    rational_sub_mul_reduce u_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #400ms;
        $display("** rational_sub_mul_reduce: FAILED **");
        $finish;
    end

    function automatic ratio_t reduce_ratio(rsmr_pkg::in_t a, rsmr_pkg::in_t b,
                                            rsmr_pkg::in_t c, rsmr_pkg::in_t d,
                                            rsmr_pkg::in_t e, rsmr_pkg::in_t f);
        ratio_t r;
        longint diff, num, den;
        longint unsigned nm, dm, x, y, t, s;
        bit neg;
        r.num = '0;
        r.den = DW'(1);
        r.dz  = 1'b0;
        if (b == 0 || d == 0 || f == 0)
        begin
            r.dz = 1'b1;
            return r;
        end
        diff = longint'(a) * longint'(d) - longint'(c) * longint'(b);
        num  = diff * longint'(e);
        den  = longint'(b) * longint'(d) * longint'(f);
        if (num == 0)
            return r;
        neg = (num < 0) != (den < 0);
        nm = (num < 0) ? -num : num;
        dm = (den < 0) ? -den : den;
        x = nm;
        y = dm;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        nm = nm / x;
        dm = dm / x;
        s = neg ? -nm : nm;
        r.num = s[NW-1:0];
        r.den = dm[DW-1:0];
        return r;
    endfunction

    task automatic add_row(int a, int b, int c, int d, int e, int f, bit typed = 0,
                           longint n = 0, longint unsigned dn = 1, bit z = 0);
        row_t r;
        r.a = rsmr_pkg::in_t'(a);
        r.b = rsmr_pkg::in_t'(b);
        r.c = rsmr_pkg::in_t'(c);
        r.d = rsmr_pkg::in_t'(d);
        r.e = rsmr_pkg::in_t'(e);
        r.f = rsmr_pkg::in_t'(f);
        r.typed = typed;
        r.want.num = n[NW-1:0];
        r.want.den = dn[DW-1:0];
        r.want.dz  = z;
        stim_rows.push_back(r);
    endtask

    function automatic rsmr_pkg::in_t rand_field(bit nonzero);
        rsmr_pkg::in_t v;
        int pick;
        pick = int'($urandom_range(0, 5));
        case (pick)
            0: v = rsmr_pkg::in_t'(int'($urandom_range(0, 8)) - 4);
            1:
            begin
                if ($urandom_range(0, 1) != 0)
                    v = rsmr_pkg::in_t'({1'b0, {(IW-1){1'b1}}});
                else
                    v = rsmr_pkg::in_t'({1'b1, {(IW-1){1'b0}}});
            end
            default: v = rsmr_pkg::in_t'($urandom);
        endcase
        if (nonzero && v == 0)
            v = rsmr_pkg::in_t'(1);
        return v;
    endfunction

    task automatic send_row(row_t r);
        ratio_t w;
        int gap;
        gap = int'($urandom_range(0, 19));
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        w = reduce_ratio(r.a, r.b, r.c, r.d, r.e, r.f);
        if (r.typed)
            w = r.want;
        in_valid   <= 1'b1;
        first_num  <= r.a;
        first_den  <= r.b;
        second_num <= r.c;
        second_den <= r.d;
        factor_num <= r.e;
        factor_den <= r.f;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_ratios.push_back(w);
        sent_count++;
        if (w.dz)
            dz_count++;
    endtask

    initial
    begin
        row_t r;
        rst_n = 1'b0;
        in_valid = 1'b0;
        {first_num, first_den, second_num, second_den, factor_num, factor_den} = '0;
        send_done = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(0, 1, 0, 1, 0, 1, 1, 0, 1, 0);
        add_row(1, 0, 1, 1, 1, 1, 1, 0, 1, 1);
        add_row(1, 1, 1, 0, 1, 1, 1, 0, 1, 1);
        add_row(1, 1, 1, 1, 1, 0, 1, 0, 1, 1);
        add_row(0, 0, 0, 0, 0, 0, 1, 0, 1, 1);
        add_row(1, 2, 1, 3, 1, 1, 1, 1, 6, 0);
        add_row(1, 2, 1, 2, 5, 7, 1, 0, 1, 0);
        add_row(3, 4, 1, 4, 2, 1, 1, 1, 1, 0);
        add_row(1, 2, 1, 3, -1, 1, 1, -1, 6, 0);
        add_row(1, -2, 1, 3, 1, 1, 1, -5, 6, 0);
        add_row(-32768, 1, 32767, 1, -32768, 1);
        add_row(-32768, -32768, -32768, -32768, -32768, -32768);
        add_row(32767, 32767, -32768, 32767, 32767, 32767);
        add_row(-32768, 32767, 32767, -32768, -32768, 32767);
        add_row(32767, 1, -32768, 1, 32767, -32768);
        add_row(1, 32767, -1, -32768, 1, 32767);
        add_row(1, -1, 1, -1, 1, -1);
        add_row(-1, -1, -1, 1, -1, -1);
        add_row(7, 9, 3, 5, 15, 28);
        foreach (stim_rows[i])
            send_row(stim_rows[i]);

        in_valid <= 1'b0;
        while (pending_ratios.size() != 0)
            @(posedge clk);

        for (int i = 0; i < 400; i++)
        begin
            r.typed = 0;
            r.a = rand_field(0);
            r.b = rand_field($urandom_range(0, 15) != 0);
            r.c = rand_field(0);
            r.d = rand_field($urandom_range(0, 15) != 0);
            r.e = rand_field(0);
            r.f = rand_field($urandom_range(0, 15) != 0);
            send_row(r);
        end
        in_valid <= 1'b0;
        send_done = 1;
    end

    initial
    begin
        ratio_t w;
        int gap;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            gap = int'($urandom_range(0, 19));
            if (gap != 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            got_count++;
            if (pending_ratios.size() == 0)
            begin
                $display("%t: transaction with none expected: %0d/%0d dz %0b", $realtime,
                         ratio_num, result_den, div_by_zero);
                fail_count++;
            end
            else
            begin
                w = pending_ratios.pop_front();
                if (ratio_num !== w.num || result_den !== w.den || div_by_zero !== w.dz)
                begin
                    $display("%t: expected %0d/%0d dz %0b, actual %0d/%0d dz %0b", $realtime,
                             w.num, w.den, w.dz, ratio_num, result_den, div_by_zero);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        wait (send_done);
        while (pending_ratios.size() != 0)
            @(posedge clk);
        repeat (3000) @(posedge clk);
        if (pending_ratios.size() != 0)
            fail_count++;
        $display("sent %0d transactions (%0d with a zero denominator), received %0d results",
                 sent_count, dz_count, got_count);
        $display("covered field extremes, sign cases, zero numerators and random fractions");
        if (fail_count == 0)
            $display("** rational_sub_mul_reduce: PASSED **");
        else
            $display("** rational_sub_mul_reduce: FAILED **");
        $finish;
    end
endmodule
